@@ rtl/rfft_pkg.sv @@
package rfft_pkg;

    localparam int MAX_LOG2 = 10;
    localparam int AW       = MAX_LOG2;
    localparam int DEPTH    = 1 << MAX_LOG2;
    localparam int SW       = 16;
    localparam int TW       = 16;
    localparam int WW       = 26;
    localparam int PW       = WW + TW;
    localparam int ROM_AW   = MAX_LOG2 - 2;
    localparam int ROM_LEN  = 1 << ROM_AW;
    localparam int LW       = 4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_READ,
        ST_MUL,
        ST_CALC,
        ST_WRITE
    } t_state;

    typedef enum logic [1:0] {
        OP_TRIV,
        OP_BFLY,
        OP_NEG
    } t_op_kind;

    typedef struct packed {
        t_op_kind                  kind;
        logic [2:0]                nw;
        logic [3:0][AW-1:0]        addr;
        logic [ROM_AW-1:0]         m;
    } t_op;

    typedef logic [TW-1:0] t_rom [ROM_LEN];

    // restoring long division, nonnegative operands, elaboration only
    function automatic longint f_udiv(input longint num, input longint den);
        longint q;
        longint r;
        q = 0;
        r = 0;
        for (int i = 62; i >= 0; i--) begin
            r = (r << 1) | ((num >> i) & longint'(1));
            if (r >= den) begin
                r = r - den;
                q = q | (longint'(1) << i);
            end
        end
        return q;
    endfunction

    // quotient truncated toward zero, positive divisor
    function automatic longint f_div(input longint num, input longint den);
        longint q;
        q = f_udiv((num < 0) ? -num : num, den);
        return (num < 0) ? -q : q;
    endfunction

    function automatic t_rom f_build_rom(input logic is_sin);
        t_rom   rom;
        longint two_pi;
        longint one;
        longint x;
        longint x2;
        longint tc;
        longint ts;
        longint c;
        longint s;
        longint v;
        longint r;
        longint top;
        two_pi = f_udiv(longint'(2292816) << 40, longint'(364913));
        one    = longint'(1) << 30;
        top    = (longint'(1) << (TW - 1)) - 1;
        for (int m = 0; m < ROM_LEN; m++) begin
            x  = (two_pi * longint'(m)) >>> (MAX_LOG2 + 10);
            x2 = (x * x) >>> 30;
            tc = one;
            ts = x;
            c  = one;
            s  = x;
            for (int k = 1; k <= 12; k++) begin
                tc = -f_div(tc * x2, longint'((2 * k - 1) * (2 * k)) << 30);
                ts = -f_div(ts * x2, longint'((2 * k) * (2 * k + 1)) << 30);
                c  = c + tc;
                s  = s + ts;
            end
            if (c < 0) c = 0;
            if (s < 0) s = 0;
            v = is_sin ? s : c;
            r = (v + (longint'(1) << (30 - TW))) >>> (31 - TW);
            rom[m] = (r > top) ? TW'(top) : TW'(r);
        end
        return rom;
    endfunction

    localparam t_rom COS_ROM = f_build_rom(1'b0);
    localparam t_rom SIN_ROM = f_build_rom(1'b1);

    function automatic logic signed [WW-1:0] f_sat(input logic signed [WW+2:0] v);
        logic signed [WW+2:0] hi;
        logic signed [WW+2:0] lo;
        hi = (WW+3)'((longint'(1) << (WW - 1)) - 1);
        lo = -hi - (WW+3)'(1);
        if (v > hi) return WW'(hi);
        if (v < lo) return WW'(lo);
        return WW'(v);
    endfunction

endpackage

@@ rtl/rfft_ram.sv @@
module rfft_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/rfft_seq.sv @@
module rfft_seq (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_next,
    input  logic [rfft_pkg::LW-1:0]        i_lg,
    output rfft_pkg::t_op                  o_op,
    output logic                           o_active
);

    logic                          r_active;
    logic [rfft_pkg::LW-1:0]       r_pass;
    rfft_pkg::t_op_kind            r_kind;
    logic [rfft_pkg::AW-1:0]       r_grp;
    logic [rfft_pkg::ROM_AW-1:0]   r_a;

    logic [rfft_pkg::AW-1:0]       o_base;
    logic [rfft_pkg::AW-1:0]       h;
    logic [rfft_pkg::AW-1:0]       p;
    logic [rfft_pkg::AW-1:0]       a_ext;
    logic [rfft_pkg::AW-1:0]       q_last;
    logic [rfft_pkg::ROM_AW-1:0]   a_last;
    logic                          last_b;

    always_comb begin
        o_base = rfft_pkg::AW'({{rfft_pkg::AW{1'b0}}, r_grp} << r_pass);
        h      = rfft_pkg::AW'((rfft_pkg::AW+1)'(1) << (r_pass - rfft_pkg::LW'(1)));
        p      = rfft_pkg::AW'((rfft_pkg::AW+1)'(1) << r_pass);
        a_ext  = rfft_pkg::AW'(r_a);
        q_last = rfft_pkg::AW'(((rfft_pkg::AW+1)'(1) << i_lg) >> r_pass) - rfft_pkg::AW'(1);
        a_last = rfft_pkg::ROM_AW'((h >> 1) - rfft_pkg::AW'(1));
        last_b = (r_grp == q_last);
    end

    always_comb begin
        o_op.kind = r_kind;
        o_op.m    = rfft_pkg::ROM_AW'({{rfft_pkg::AW{1'b0}}, r_a}
                    << (rfft_pkg::LW'(rfft_pkg::MAX_LOG2) - r_pass));
        o_op.addr = '0;
        o_op.nw   = 3'd1;
        unique case (r_kind)
            rfft_pkg::OP_TRIV: begin
                o_op.nw      = 3'd2;
                o_op.addr[0] = o_base;
                o_op.addr[1] = o_base + h;
            end
            rfft_pkg::OP_BFLY: begin
                o_op.nw      = 3'd4;
                o_op.addr[0] = o_base + a_ext;
                o_op.addr[1] = o_base + h - a_ext;
                o_op.addr[2] = o_base + h + a_ext;
                o_op.addr[3] = o_base + p - a_ext;
            end
            rfft_pkg::OP_NEG: begin
                o_op.nw      = 3'd1;
                o_op.addr[0] = o_base + h + (h >> 1);
            end
            default: begin
                o_op.nw = 3'd1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_pass   <= '0;
            r_kind   <= rfft_pkg::OP_TRIV;
            r_grp    <= '0;
            r_a      <= '0;
        end else if (i_start) begin
            r_active <= (i_lg != '0);
            r_pass   <= rfft_pkg::LW'(1);
            r_kind   <= rfft_pkg::OP_TRIV;
            r_grp    <= '0;
            r_a      <= '0;
        end else if (i_next) begin
            if (!last_b) begin
                r_grp <= r_grp + rfft_pkg::AW'(1);
            end else begin
                r_grp <= '0;
                unique case (r_kind)
                    rfft_pkg::OP_TRIV: begin
                        if (r_pass >= rfft_pkg::LW'(3)) begin
                            r_kind <= rfft_pkg::OP_BFLY;
                            r_a    <= rfft_pkg::ROM_AW'(1);
                        end else if (r_pass == rfft_pkg::LW'(2)) begin
                            r_kind <= rfft_pkg::OP_NEG;
                        end else if (r_pass == i_lg) begin
                            r_active <= 1'b0;
                        end else begin
                            r_pass <= r_pass + rfft_pkg::LW'(1);
                        end
                    end
                    rfft_pkg::OP_BFLY: begin
                        if (r_a == a_last) begin
                            r_kind <= rfft_pkg::OP_NEG;
                        end else begin
                            r_a <= r_a + rfft_pkg::ROM_AW'(1);
                        end
                    end
                    default: begin
                        r_kind <= rfft_pkg::OP_TRIV;
                        if (r_pass == i_lg) begin
                            r_active <= 1'b0;
                        end else begin
                            r_pass <= r_pass + rfft_pkg::LW'(1);
                        end
                    end
                endcase
            end
        end
    end

    assign o_active = r_active;

endmodule

@@ rtl/real_fft_radix2_halfcomplex_core.sv @@
// Real-input radix-2 FFT, halfcomplex output, 2^log2_size points (1..1024).
// Input: a sample word is taken at a clock edge with start high and busy low.
// Each accepted sample is written, bit-reversed, into the work RAM bank, and
// the spectrum word of the previous frame at the same index is read from the
// other bank. That result appears on the o_ result ports in the cycle after the
// accept, for one cycle, marked by o_res_stb; the receiver cannot stall.
// Before the first full frame, results carry o_valid_res 0 and o_coefficient 0.
// Within a frame a sample can be taken every cycle. After the last sample of
// a frame busy rises and the transform runs in place in the work bank; the
// two banks then swap roles. Every butterfly moves its words one at a time
// through the single read and write port of the bank, and no sample is taken
// until busy falls again. A size-1 frame runs no butterfly pass.
// Config: i_cfg_we writes log2_size (values above 10 clamp to 10), restarts
// the frame and drops the held spectrum. Write only while busy is low.
// Reset: log2_size = 10, no spectrum held, frame position 0.
module real_fft_radix2_halfcomplex_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [rfft_pkg::SW-1:0]    i_sample,
    input  logic                              i_cfg_we,
    input  logic [rfft_pkg::LW-1:0]           i_cfg_data,
    output logic                              o_res_stb,
    output logic                              o_valid_res,
    output logic [rfft_pkg::AW-1:0]           o_bin_index,
    output logic signed [rfft_pkg::WW-1:0]    o_coefficient,
    output logic                              o_frame_end
);

    rfft_pkg::t_state                r_state;
    rfft_pkg::t_state                n_state;
    logic [2:0]                      r_step;
    logic [rfft_pkg::LW-1:0]         r_lg;
    logic [rfft_pkg::AW-1:0]         r_fill;
    logic                            r_have;
    logic                            r_sel;

    logic                            r_out_stb;
    logic                            r_out_valid;
    logic [rfft_pkg::AW-1:0]         r_out_bin;
    logic                            r_out_end;
    logic                            r_rd_bank;

    logic signed [rfft_pkg::WW-1:0]  r_z [4];
    logic signed [rfft_pkg::PW-1:0]  r_p [4];
    logic [rfft_pkg::TW-1:0]         r_c;
    logic [rfft_pkg::TW-1:0]         r_s;
    logic signed [rfft_pkg::WW+1:0]  r_wr;
    logic signed [rfft_pkg::WW+1:0]  r_wi;

    logic                            accept;
    logic                            complete;
    logic [rfft_pkg::AW-1:0]         n_last;
    logic [rfft_pkg::AW-1:0]         rev_full;
    logic [rfft_pkg::AW-1:0]         rev_addr;
    logic                            seq_start;
    logic                            seq_next;
    logic                            finish;
    logic                            seq_active;
    rfft_pkg::t_op                   op;
    logic                            rd_last;
    logic                            wr_last;

    logic [rfft_pkg::AW-1:0]         raddr;
    logic [rfft_pkg::AW-1:0]         waddr;
    logic [rfft_pkg::WW-1:0]         wdata;
    logic                            we;
    logic                            we0;
    logic                            we1;
    logic [rfft_pkg::WW-1:0]         rd0;
    logic [rfft_pkg::WW-1:0]         rd1;
    logic signed [rfft_pkg::WW-1:0]  rd_w;
    logic signed [rfft_pkg::WW+2:0]  wsum;
    logic signed [rfft_pkg::TW-1:0]  mul_tw;
    logic signed [rfft_pkg::WW-1:0]  mul_z;
    logic signed [rfft_pkg::PW:0]    sum_r;
    logic signed [rfft_pkg::PW:0]    sum_i;

    assign busy     = (r_state != rfft_pkg::ST_IDLE);
    assign accept   = start && !busy;
    assign n_last   = rfft_pkg::AW'(((rfft_pkg::AW+1)'(1) << r_lg) - (rfft_pkg::AW+1)'(1));
    assign complete = (r_fill == n_last);
    assign rd_last  = (r_step == op.nw);
    assign wr_last  = (r_step == (op.nw - 3'd1));

    always_comb begin
        for (int b = 0; b < rfft_pkg::AW; b++) begin
            rev_full[b] = r_fill[rfft_pkg::AW-1-b];
        end
        rev_addr = rev_full >> (rfft_pkg::LW'(rfft_pkg::MAX_LOG2) - r_lg);
    end

    rfft_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (seq_start),
        .i_next   (seq_next),
        .i_lg     (r_lg),
        .o_op     (op),
        .o_active (seq_active)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rfft_pkg::ST_IDLE: begin
                if (accept && complete) n_state = rfft_pkg::ST_CHECK;
            end
            rfft_pkg::ST_CHECK: begin
                n_state = seq_active ? rfft_pkg::ST_READ : rfft_pkg::ST_IDLE;
            end
            rfft_pkg::ST_READ: begin
                if (rd_last) begin
                    n_state = (op.kind == rfft_pkg::OP_BFLY) ? rfft_pkg::ST_MUL
                                                             : rfft_pkg::ST_WRITE;
                end
            end
            rfft_pkg::ST_MUL: begin
                if (r_step == 3'd3) n_state = rfft_pkg::ST_CALC;
            end
            rfft_pkg::ST_CALC: begin
                n_state = rfft_pkg::ST_WRITE;
            end
            rfft_pkg::ST_WRITE: begin
                if (wr_last) n_state = rfft_pkg::ST_CHECK;
            end
            default: begin
                n_state = rfft_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer handshake, finish flag and RAM port controls
    always_comb begin
        seq_start = (r_state == rfft_pkg::ST_IDLE) && accept && complete;
        seq_next  = (r_state == rfft_pkg::ST_WRITE) && wr_last;
        finish    = (r_state == rfft_pkg::ST_CHECK) && !seq_active;
        raddr     = (r_state == rfft_pkg::ST_READ) ? op.addr[r_step[1:0]] : r_fill;
        waddr     = (r_state == rfft_pkg::ST_WRITE) ? op.addr[r_step[1:0]] : rev_addr;
        we        = (r_state == rfft_pkg::ST_WRITE) || accept;
    end

    // write-back word
    always_comb begin
        wsum = '0;
        unique case (op.kind)
            rfft_pkg::OP_TRIV: begin
                wsum = r_step[0] ? ((rfft_pkg::WW+3)'(r_z[0]) - (rfft_pkg::WW+3)'(r_z[1]))
                                 : ((rfft_pkg::WW+3)'(r_z[0]) + (rfft_pkg::WW+3)'(r_z[1]));
            end
            rfft_pkg::OP_BFLY: begin
                unique case (r_step[1:0])
                    2'd0: wsum = (rfft_pkg::WW+3)'(r_z[0]) + (rfft_pkg::WW+3)'(r_wr);
                    2'd1: wsum = (rfft_pkg::WW+3)'(r_z[0]) - (rfft_pkg::WW+3)'(r_wr);
                    2'd2: wsum = (rfft_pkg::WW+3)'(r_wi) - (rfft_pkg::WW+3)'(r_z[1]);
                    2'd3: wsum = (rfft_pkg::WW+3)'(r_z[1]) + (rfft_pkg::WW+3)'(r_wi);
                    default: wsum = '0;
                endcase
            end
            default: begin
                wsum = -(rfft_pkg::WW+3)'(r_z[0]);
            end
        endcase
        wdata = (r_state == rfft_pkg::ST_WRITE)
                ? rfft_pkg::f_sat(wsum)
                : rfft_pkg::WW'(i_sample);
    end

    assign we0  = we && r_sel;
    assign we1  = we && !r_sel;
    assign rd_w = r_sel ? rd0 : rd1;

    rfft_ram #(.WIDTH(rfft_pkg::WW), .DEPTH(rfft_pkg::DEPTH)) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (we0),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd0)
    );

    rfft_ram #(.WIDTH(rfft_pkg::WW), .DEPTH(rfft_pkg::DEPTH)) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (we1),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd1)
    );

    // twiddle multiply: c*z1r, s*z1i, c*z1i, s*z1r; sums carry the rounding half
    assign mul_tw = r_step[0] ? $signed(r_s) : $signed(r_c);
    assign mul_z  = (r_step[0] ^ r_step[1]) ? r_z[3] : r_z[2];
    assign sum_r  = (rfft_pkg::PW+1)'(r_p[0]) + (rfft_pkg::PW+1)'(r_p[1])
                    + ((rfft_pkg::PW+1)'(1) << (rfft_pkg::TW - 2));
    assign sum_i  = (rfft_pkg::PW+1)'(r_p[2]) - (rfft_pkg::PW+1)'(r_p[3])
                    + ((rfft_pkg::PW+1)'(1) << (rfft_pkg::TW - 2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rfft_pkg::ST_IDLE;
            r_step    <= '0;
            r_lg      <= rfft_pkg::LW'(rfft_pkg::MAX_LOG2);
            r_fill    <= '0;
            r_have    <= 1'b0;
            r_sel     <= 1'b0;
            r_out_stb <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_step    <= (n_state != r_state) ? 3'd0 : r_step + 3'd1;
            r_out_stb <= accept;
            if (i_cfg_we) begin
                r_lg   <= (i_cfg_data > rfft_pkg::LW'(rfft_pkg::MAX_LOG2))
                          ? rfft_pkg::LW'(rfft_pkg::MAX_LOG2) : i_cfg_data;
                r_fill <= '0;
                r_have <= 1'b0;
            end else if (accept) begin
                r_fill <= complete ? '0 : r_fill + rfft_pkg::AW'(1);
            end
            if (finish) begin
                r_have <= 1'b1;
                r_sel  <= !r_sel;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_valid <= r_have;
            r_out_bin   <= r_fill;
            r_out_end   <= r_have && complete;
            r_rd_bank   <= r_sel;
        end
        if (r_state == rfft_pkg::ST_READ) begin
            if (r_step == 3'd0) begin
                r_c <= rfft_pkg::COS_ROM[op.m];
                r_s <= rfft_pkg::SIN_ROM[op.m];
            end else begin
                r_z[2'(r_step - 3'd1)] <= rd_w;
            end
        end
        if (r_state == rfft_pkg::ST_MUL) begin
            r_p[r_step[1:0]] <= rfft_pkg::PW'(mul_tw * mul_z);
        end
        if (r_state == rfft_pkg::ST_CALC) begin
            r_wr <= (rfft_pkg::WW+2)'(sum_r >>> (rfft_pkg::TW - 1));
            r_wi <= (rfft_pkg::WW+2)'(sum_i >>> (rfft_pkg::TW - 1));
        end
    end

    assign o_res_stb     = r_out_stb;
    assign o_valid_res   = r_out_valid;
    assign o_bin_index   = r_out_bin;
    assign o_frame_end   = r_out_end;
    assign o_coefficient = r_out_valid ? (r_rd_bank ? rd1 : rd0) : '0;

    a_no_spec_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rfft_pkg::ST_WRITE) |-> (r_sel ? !we1 : !we0))
        else $error("transform wrote into the spectrum bank");

    a_busy_after_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && complete && !i_cfg_we) |=> busy)
        else $error("frame completed without starting the transform");

    a_swap_on_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (finish && !i_cfg_we) |=> (r_sel != $past(r_sel)) && r_have)
        else $error("banks not swapped at end of transform");

    a_end_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_stb && o_frame_end) |-> o_valid_res)
        else $error("frame end marked without a spectrum");

endmodule
